/* src/ppr_pkg.sv */
// Shared types and constants for the polar pair to rectangular sum core.
// Holds the CORDIC arctangent table, gain constant and stage payload struct.
`timescale 1ns / 1ps
package ppr_pkg;

  localparam int PPR_MAX_STAGES = 24;
  localparam int PPR_CW         = 35;  // Q8.24 coordinate plus growth
  localparam int PPR_ZW         = 30;  // residual angle, degrees * 2^22

  localparam logic signed [17:0] PPR_TURN       = 18'sd23040;
  localparam logic signed [17:0] PPR_TWO_TURNS  = 18'sd46080;
  localparam logic [14:0]        PPR_Q1_START   = 15'd5760;
  localparam logic [14:0]        PPR_Q2_START   = 15'd11520;
  localparam logic [14:0]        PPR_Q3_START   = 15'd17280;
  localparam logic [12:0]        PPR_EIGHTH     = 13'd2880;
  localparam logic signed [13:0] PPR_QUARTER    = 14'sd5760;
  localparam logic [29:0]        PPR_INV_GAIN   = 30'd652032874;
  localparam logic signed [18:0] PPR_COORD_MAX  = 19'sd65535;

  localparam logic [1:0] PPR_QUAD0 = 2'd0;
  localparam logic [1:0] PPR_QUAD1 = 2'd1;
  localparam logic [1:0] PPR_QUAD2 = 2'd2;
  localparam logic [1:0] PPR_QUAD3 = 2'd3;

  localparam logic [27:0] PPR_ATAN [PPR_MAX_STAGES] = '{
    28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
    28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
    28'd938729,    28'd469366,    28'd234683,   28'd117342,
    28'd58671,     28'd29335,     28'd14668,    28'd7334,
    28'd3667,      28'd1833,      28'd917,      28'd458,
    28'd229,       28'd115,       28'd57,       28'd29
  };

  typedef struct packed {
    logic signed [PPR_CW-1:0] x;
    logic signed [PPR_CW-1:0] y;
    logic signed [PPR_ZW-1:0] z;
    logic [1:0]               quad;
  } ppr_rot_t;

endpackage

/* src/ppr_reduce.sv */
// Front end of one conversion lane: angle wrap, gain-compensated start value,
// then quadrant split. Two register stages. Depends on ppr_pkg.
`timescale 1ns / 1ps
module ppr_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [15:0]        mag,
  input  logic signed [15:0] deg,
  output logic               out_valid,
  output ppr_pkg::ppr_rot_t  out_rot
);
  import ppr_pkg::*;

  logic signed [17:0] deg_ext;
  logic signed [17:0] wrap;
  logic [45:0]        prod;
  logic               v1;
  logic [14:0]        ang;
  logic [31:0]        x_init;
  logic [1:0]         quad_raw;
  logic [12:0]        res;
  logic [1:0]         quad_fix;
  logic signed [13:0] res_fix;

  always_comb begin
    deg_ext = 18'(deg);
    if (deg_ext < -PPR_TURN) begin
      wrap = deg_ext + PPR_TWO_TURNS;
    end else if (deg_ext < 18'sd0) begin
      wrap = deg_ext + PPR_TURN;
    end else if (deg_ext >= PPR_TURN) begin
      wrap = deg_ext - PPR_TURN;
    end else begin
      wrap = deg_ext;
    end
    prod = 46'(mag) * 46'(PPR_INV_GAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ang    <= wrap[14:0];
    x_init <= prod[45:14];
  end

  always_comb begin
    if (ang >= PPR_Q3_START) begin
      quad_raw = PPR_QUAD3;
      res      = 13'(ang - PPR_Q3_START);
    end else if (ang >= PPR_Q2_START) begin
      quad_raw = PPR_QUAD2;
      res      = 13'(ang - PPR_Q2_START);
    end else if (ang >= PPR_Q1_START) begin
      quad_raw = PPR_QUAD1;
      res      = 13'(ang - PPR_Q1_START);
    end else begin
      quad_raw = PPR_QUAD0;
      res      = ang[12:0];
    end
    if (res > PPR_EIGHTH) begin
      res_fix  = $signed({1'b0, res}) - PPR_QUARTER;
      quad_fix = quad_raw + 2'd1;
    end else begin
      res_fix  = $signed({1'b0, res});
      quad_fix = quad_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    out_rot.x    <= $signed({3'b000, x_init});
    out_rot.y    <= '0;
    out_rot.z    <= {res_fix, 16'b0};
    out_rot.quad <= quad_fix;
  end

endmodule

/* src/ppr_rot_stage.sv */
// One registered CORDIC rotation step (shift-add micro-rotation).
// Depends on ppr_pkg for the arctangent table and payload struct.
`timescale 1ns / 1ps
module ppr_rot_stage #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ppr_pkg::ppr_rot_t in_rot,
  output logic              out_valid,
  output ppr_pkg::ppr_rot_t out_rot
);
  import ppr_pkg::*;

  localparam logic signed [PPR_ZW-1:0] ATAN = $signed(PPR_ZW'(PPR_ATAN[IDX]));

  logic signed [PPR_CW-1:0] dx;
  logic signed [PPR_CW-1:0] dy;
  ppr_rot_t                 rot_next;

  always_comb begin
    dx            = in_rot.y >>> IDX;
    dy            = in_rot.x >>> IDX;
    rot_next.quad = in_rot.quad;
    if (!in_rot.z[PPR_ZW-1]) begin
      rot_next.x = in_rot.x - dx;
      rot_next.y = in_rot.y + dy;
      rot_next.z = in_rot.z - ATAN;
    end else begin
      rot_next.x = in_rot.x + dx;
      rot_next.y = in_rot.y - dy;
      rot_next.z = in_rot.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rot <= rot_next;
  end

endmodule

/* src/ppr_finish.sv */
// Back end of one lane: round Q8.24 to Q8.8, saturate, apply quarter turns.
// One register stage. Depends on ppr_pkg.
`timescale 1ns / 1ps
module ppr_finish (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ppr_pkg::ppr_rot_t  in_rot,
  output logic               out_valid,
  output logic signed [16:0] x,
  output logic signed [16:0] y
);
  import ppr_pkg::*;

  function automatic logic signed [16:0] round_sat(input logic signed [PPR_CW-1:0] v);
    logic signed [PPR_CW-1:0] t;
    logic signed [18:0]       r;
    t = v + PPR_CW'(32768);
    r = 19'(t >>> 16);
    if (r > PPR_COORD_MAX) begin
      return 17'(PPR_COORD_MAX);
    end else if (r < -PPR_COORD_MAX) begin
      return 17'(-PPR_COORD_MAX);
    end
    return r[16:0];
  endfunction

  logic signed [16:0] cx;
  logic signed [16:0] cy;
  logic signed [16:0] x_next;
  logic signed [16:0] y_next;

  always_comb begin
    cx = round_sat(in_rot.x);
    cy = round_sat(in_rot.y);
    case (in_rot.quad)
      PPR_QUAD0: begin
        x_next = cx;
        y_next = cy;
      end
      PPR_QUAD1: begin
        x_next = -cy;
        y_next = cx;
      end
      PPR_QUAD2: begin
        x_next = -cx;
        y_next = -cy;
      end
      default: begin
        x_next = cy;
        y_next = -cx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    x <= x_next;
    y <= y_next;
  end

endmodule

/* src/ppr_lane.sv */
// One polar to rectangular conversion lane: reduce, unrolled CORDIC, finish.
// Depends on ppr_pkg, ppr_reduce, ppr_rot_stage, ppr_finish.
`timescale 1ns / 1ps
module ppr_lane #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [15:0]        mag,
  input  logic signed [15:0] deg,
  output logic               out_valid,
  output logic signed [16:0] x,
  output logic signed [16:0] y
);
  import ppr_pkg::*;

  ppr_rot_t rot_chain [ROTATION_STAGES+1];
  logic     v_chain   [ROTATION_STAGES+1];

  ppr_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mag       (mag),
    .deg       (deg),
    .out_valid (v_chain[0]),
    .out_rot   (rot_chain[0])
  );

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    ppr_rot_stage #(.IDX(i)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_chain[i]),
      .in_rot    (rot_chain[i]),
      .out_valid (v_chain[i+1]),
      .out_rot   (rot_chain[i+1])
    );
  end

  ppr_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_chain[ROTATION_STAGES]),
    .in_rot    (rot_chain[ROTATION_STAGES]),
    .out_valid (out_valid),
    .x         (x),
    .y         (y)
  );

endmodule

/* src/polar_pair_to_rect_sum_core.sv */
// Two polar points (Q8.8 magnitude, angle in 1/64 degree) in, both points in
// rectangular Q8.8 and their vector sum out. Depends on ppr_pkg and ppr_lane.
//
// A pair is taken on every clock with start high; busy is always low. Each
// pair's result is marked by a one cycle done pulse and passes through these
// registered steps in order: angle reduction, the CORDIC micro-rotations,
// rounding and quadrant fix-up, then the sum. The receiver cannot stall the
// core and must capture every beat on done.
`timescale 1ns / 1ps
module polar_pair_to_rect_sum_core #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        mag_a,
  input  logic signed [15:0] deg_a,
  input  logic [15:0]        mag_b,
  input  logic signed [15:0] deg_b,
  output logic               done,
  output logic signed [16:0] xa,
  output logic signed [16:0] ya,
  output logic signed [16:0] xb,
  output logic signed [16:0] yb,
  output logic signed [17:0] x_total,
  output logic signed [17:0] y_total
);
  import ppr_pkg::*;

  localparam int LATENCY = ROTATION_STAGES + 4;

  logic               accept;
  logic               va;
  logic               vb;
  logic signed [16:0] lxa;
  logic signed [16:0] lya;
  logic signed [16:0] lxb;
  logic signed [16:0] lyb;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ppr_lane #(.ROTATION_STAGES(ROTATION_STAGES)) u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .mag       (mag_a),
    .deg       (deg_a),
    .out_valid (va),
    .x         (lxa),
    .y         (lya)
  );

  ppr_lane #(.ROTATION_STAGES(ROTATION_STAGES)) u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .mag       (mag_b),
    .deg       (deg_b),
    .out_valid (vb),
    .x         (lxb),
    .y         (lyb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va;
    end
    xa      <= lxa;
    ya      <= lya;
    xb      <= lxb;
    yb      <= lyb;
    x_total <= 18'(lxa) + 18'(lxb);
    y_total <= 18'(lya) + 18'(lyb);
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) va == vb)
    else $error("conversion lanes out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching input beat");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (xa != -17'sd65536) && (ya != -17'sd65536)
          && (xb != -17'sd65536) && (yb != -17'sd65536))
    else $error("coordinate outside saturation range");

endmodule

/* verif/tb_polar_pair_to_rect_sum_core.sv */
// Self-checking testbench for polar_pair_to_rect_sum_core: a table of directed pairs, then
// random pairs under three sender idling profiles, checked against a CORDIC predictor or known results.
// Depends only on the RTL (ppr_pkg and the core).
`timescale 1ns / 1ps
module tb_polar_pair_to_rect_sum_core;

  localparam int  STAGES      = 16;
  localparam int  LATENCY     = STAGES + 4;
  localparam int  STALL_LIMIT = 4000;
  localparam int  RAND_PAIRS  = 750;
  localparam int  MAX_REPORTS = 10;

  localparam longint TURN      = 23040;
  localparam longint QUARTER   = 5760;
  localparam longint EIGHTH    = 2880;
  localparam longint INV_GAIN  = 652032874;
  localparam longint COORD_MAX = 65535;

  localparam longint ATAN_DEG22 [24] = '{
    188743680, 111421900, 58872272, 29884485,
    15000234,  7507429,   3754631,  1877430,
    938729,    469366,    234683,   117342,
    58671,     29335,     14668,    7334,
    3667,      1833,      917,      458,
    229,       115,       57,       29
  };

  typedef struct packed {
    logic signed [16:0] xa;
    logic signed [16:0] ya;
    logic signed [16:0] xb;
    logic signed [16:0] yb;
    logic signed [17:0] xt;
    logic signed [17:0] yt;
  } rect_sum_t;

  typedef struct packed {
    logic [15:0] mag_a;
    logic [15:0] deg_a;
    logic [15:0] mag_b;
    logic [15:0] deg_b;
    bit          known;
    rect_sum_t   want;
  } pair_row_t;

  // zero-magnitude rows have results known by inspection; the rest use the predictor
  localparam int DIR_ROWS = 20;
  localparam pair_row_t DIR_TABLE [DIR_ROWS] = '{
    '{16'd0,     16'd0,      16'd0,     16'd0,      1'b1, '0},
    '{16'd0,     16'h8000,   16'd0,     16'h7FFF,   1'b1, '0},
    '{16'd0,     16'd23040,  16'd0,     -16'sd23040, 1'b1, '0},
    '{16'd65535, 16'd0,      16'd65535, 16'd5760,   1'b0, '0},
    '{16'd65535, 16'd11520,  16'd65535, 16'd17280,  1'b0, '0},
    '{16'd65535, 16'd2880,   16'd65535, 16'd2881,   1'b0, '0},
    '{16'd65535, -16'sd2880, 16'd65535, -16'sd2881, 1'b0, '0},
    '{16'd65535, 16'd23040,  16'd65535, -16'sd23040, 1'b0, '0},
    '{16'd65535, 16'h7FFF,   16'd65535, 16'h8000,   1'b0, '0},
    '{16'd65535, 16'hFFFF,   16'd65535, 16'd1,      1'b0, '0},
    '{16'd1,     16'd0,      16'd1,     16'd5760,   1'b0, '0},
    '{16'd1,     16'd11520,  16'd1,     16'd17280,  1'b0, '0},
    '{16'h8000,  16'd8640,   16'h8000,  -16'sd8640, 1'b0, '0},
    '{16'd256,   16'd2880,   16'd256,   16'd14400,  1'b0, '0},
    '{16'h00FF,  16'd20160,  16'hFF00,  -16'sd5760, 1'b0, '0},
    '{16'd65535, 16'd23039,  16'd0,     16'd0,      1'b0, '0},
    '{16'd12345, -16'sd11520, 16'd54321, 16'd28800, 1'b0, '0},
    '{16'd65535, -16'sd17280, 16'd65535, -16'sd5761, 1'b0, '0},
    '{16'h5555,  16'h5555,   16'hAAAA,  16'hAAAA,   1'b0, '0},
    '{16'hAAAA,  16'h2AAA,   16'h5555,  16'hD555,   1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [15:0]        mag_a;
  logic signed [15:0] deg_a;
  logic [15:0]        mag_b;
  logic signed [15:0] deg_b;
  logic               done;
  logic signed [16:0] xa;
  logic signed [16:0] ya;
  logic signed [16:0] xb;
  logic signed [16:0] yb;
  logic signed [17:0] x_total;
  logic signed [17:0] y_total;

  rect_sum_t rect_want_q [$];
  int        errors;
  int        stall_cnt;

  polar_pair_to_rect_sum_core #(.ROTATION_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mag_a(mag_a), .deg_a(deg_a), .mag_b(mag_b), .deg_b(deg_b),
    .done(done), .xa(xa), .ya(ya), .xb(xb), .yb(yb),
    .x_total(x_total), .y_total(y_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint round_clamp(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < -COORD_MAX) r = -COORD_MAX;
    return r;
  endfunction

  function automatic void polar_to_rect(input logic [15:0] mag, input logic [15:0] deg,
                                        output longint xo, output longint yo);
    longint m, a, r, x, y, z, dx, dy, cx, cy;
    int     q;
    m = longint'(mag);
    a = longint'($signed(deg)) % TURN;
    if (a < 0) a += TURN;
    q = int'(a / QUARTER);
    r = a - longint'(q) * QUARTER;
    if (r > EIGHTH) begin
      r -= QUARTER;
      q = (q + 1) % 4;
    end
    x = (m * INV_GAIN) >>> 14;
    y = 0;
    z = r * 65536;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG22[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_DEG22[i];
      end
    end
    cx = round_clamp(x);
    cy = round_clamp(y);
    case (q)
      0: begin xo = cx;  yo = cy;  end
      1: begin xo = -cy; yo = cx;  end
      2: begin xo = -cx; yo = -cy; end
      default: begin xo = cy; yo = -cx; end
    endcase
  endfunction

  function automatic rect_sum_t polar_pair_rect(input logic [15:0] ma, da, mb, db);
    longint    pxa, pya, pxb, pyb, sx, sy;
    rect_sum_t res;
    polar_to_rect(ma, da, pxa, pya);
    polar_to_rect(mb, db, pxb, pyb);
    sx = pxa + pxb;
    sy = pya + pyb;
    res.xa = pxa[16:0];
    res.ya = pya[16:0];
    res.xb = pxb[16:0];
    res.yb = pyb[16:0];
    res.xt = sx[17:0];
    res.yt = sy[17:0];
    return res;
  endfunction

  function automatic logic [15:0] rand_mag();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 16'd0;
    if (sel < 16) return 16'hFFFF;
    if (sel < 45) return 16'($urandom_range(1023));
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] rand_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 16'(int'($urandom_range(46080)) - 23040);
    if (sel < 80)
      return 16'(int'($urandom_range(16)) * 2880 - 23040 + int'($urandom_range(2)) - 1);
    return 16'($urandom());
  endfunction

  task automatic send_pair(input logic [15:0] ma, da, mb, db, input bit known,
                           input rect_sum_t want, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    mag_a <= ma;
    deg_a <= da;
    mag_b <= mb;
    deg_b <= db;
    @(posedge clk);
    while (busy) @(posedge clk);
    rect_want_q.push_back(known ? want : polar_pair_rect(ma, da, mb, db));
  endtask

  // result checker and stall watchdog
  always @(posedge clk) begin
    rect_sum_t w;
    if (!rst) begin
      if (done) begin
        if (rect_want_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected beat: xa=%0d ya=%0d xb=%0d yb=%0d xt=%0d yt=%0d",
                     xa, ya, xb, yb, x_total, y_total);
        end else begin
          w = rect_want_q.pop_front();
          if (w.xa !== xa || w.ya !== ya || w.xb !== xb || w.yb !== yb ||
              w.xt !== x_total || w.yt !== y_total) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: want %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                       w.xa, w.ya, w.xb, w.yb, w.xt, w.yt,
                       xa, ya, xb, yb, x_total, y_total);
          end
        end
      end
      if ((start && !busy) || done) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    rect_sum_t   none;
    logic [15:0] ma, da, mb, db;
    int          pct;
    clk       = 1'b0;
    rst       = 1'b1;
    start     = 1'b0;
    mag_a     = '0;
    deg_a     = '0;
    mag_b     = '0;
    deg_b     = '0;
    errors    = 0;
    stall_cnt = 0;
    none      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TABLE[i])
      send_pair(DIR_TABLE[i].mag_a, DIR_TABLE[i].deg_a, DIR_TABLE[i].mag_b,
                DIR_TABLE[i].deg_b, DIR_TABLE[i].known, DIR_TABLE[i].want, 29);

    for (int n = 0; n < RAND_PAIRS; n++) begin
      pct = (n < RAND_PAIRS / 3) ? 29 : (n < 2 * RAND_PAIRS / 3) ? 63 : 0;
      ma = rand_mag();
      da = rand_angle();
      mb = rand_mag();
      db = rand_angle();
      send_pair(ma, da, mb, db, 1'b0, none, pct);
    end

    @(negedge clk);
    start <= 1'b0;
    while (rect_want_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (errors == 0 && rect_want_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/ppr_pkg.sv
src/ppr_reduce.sv
src/ppr_rot_stage.sv
src/ppr_finish.sv
src/ppr_lane.sv
src/polar_pair_to_rect_sum_core.sv
verif/tb_polar_pair_to_rect_sum_core.sv
